FILE: hw/rtl/bdf_pkg.sv
// Shared types and constants of the biquad sample filter.
package bdf_pkg;

   localparam int COEF_BITS      = 32;
   localparam int HIST_BITS      = 32;
   localparam int ACC_BITS       = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COEF_B0 = 3'd0,
      REG_COEF_B1 = 3'd1,
      REG_COEF_B2 = 3'd2,
      REG_COEF_A1 = 3'd3,
      REG_COEF_A2 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
   } coef_set_type;

endpackage

FILE: hw/rtl/bdf_csr.sv
// Coefficient registers of the biquad filter and the history clear on write.
module bdf_csr
   import bdf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output coef_set_type              coef,
   output logic                      hist_clear
);

   coef_set_type coef_ff;
   coef_set_type coef_in;
   logic         hit;

   always_comb begin
      coef_in = coef_ff;
      hit     = 1'b0;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_COEF_B0: begin
               coef_in.b0 = csr_wdata;
               hit        = 1'b1;
            end
            REG_COEF_B1: begin
               coef_in.b1 = csr_wdata;
               hit        = 1'b1;
            end
            REG_COEF_B2: begin
               coef_in.b2 = csr_wdata;
               hit        = 1'b1;
            end
            REG_COEF_A1: begin
               coef_in.a1 = csr_wdata;
               hit        = 1'b1;
            end
            REG_COEF_A2: begin
               coef_in.a2 = csr_wdata;
               hit        = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef       = coef_ff;
   assign hist_clear = hit;

endmodule

FILE: hw/rtl/bdf_math.sv
// One biquad evaluation: five products, wrapping sum, rounding and saturation.
module bdf_math
   import bdf_pkg::*;
#(
   parameter int SAMPLE_BITS    = 12,
   parameter int X_BITS         = 13,
   parameter int COEF_FRAC_BITS = 28,
   parameter int OUT_FRAC_BITS  = 12,
   parameter int MID_SCALE      = 2048
)
(
   input  coef_set_type                 coef,
   input  logic signed [X_BITS-1:0]     x0,
   input  logic signed [X_BITS-1:0]     x1,
   input  logic signed [X_BITS-1:0]     x2,
   input  logic signed [HIST_BITS-1:0]  y1,
   input  logic signed [HIST_BITS-1:0]  y2,
   output logic signed [HIST_BITS-1:0]  y_next,
   output logic [SAMPLE_BITS-1:0]       code
);

   localparam int PX_BITS = COEF_BITS + X_BITS;
   localparam logic signed [ACC_BITS-1:0] Y_MAX    = ACC_BITS'((64'sd1 <<< (HIST_BITS-1)) - 1);
   localparam logic signed [ACC_BITS-1:0] Y_MIN    = -(ACC_BITS'(64'sd1 <<< (HIST_BITS-1)));
   localparam logic signed [ACC_BITS-1:0] MID_ACC  = ACC_BITS'(MID_SCALE);
   localparam logic signed [ACC_BITS-1:0] CODE_MAX = ACC_BITS'((64'sd1 <<< SAMPLE_BITS) - 1);

   logic signed [PX_BITS-1:0]  pb0, pb1, pb2;
   logic signed [ACC_BITS-1:0] pa1, pa2;
   logic signed [ACC_BITS-1:0] ff0, ff1, ff2;
   logic signed [ACC_BITS-1:0] acc;
   logic signed [ACC_BITS-1:0] y_half, y_round;
   logic signed [ACC_BITS-1:0] c_half, c_round, c_mid;

   assign pb0 = coef.b0 * x0;
   assign pb1 = coef.b1 * x1;
   assign pb2 = coef.b2 * x2;
   assign pa1 = coef.a1 * y1;
   assign pa2 = coef.a2 * y2;

   assign ff0 = ACC_BITS'(pb0) <<< OUT_FRAC_BITS;
   assign ff1 = ACC_BITS'(pb1) <<< OUT_FRAC_BITS;
   assign ff2 = ACC_BITS'(pb2) <<< OUT_FRAC_BITS;

   assign acc = ff0 + ff1 + ff2 - pa1 - pa2;

   assign y_half  = (acc >>> (COEF_FRAC_BITS - 1)) + 64'sd1;
   assign y_round = y_half >>> 1;

   assign c_half  = (acc >>> (COEF_FRAC_BITS + OUT_FRAC_BITS - 1)) + 64'sd1;
   assign c_round = c_half >>> 1;
   assign c_mid   = c_round + MID_ACC;

   always_comb begin
      if (y_round > Y_MAX) begin
         y_next = HIST_BITS'(Y_MAX);
      end else if (y_round < Y_MIN) begin
         y_next = HIST_BITS'(Y_MIN);
      end else begin
         y_next = HIST_BITS'(y_round);
      end
   end

   always_comb begin
      if (c_mid < 0) begin
         code = '0;
      end else if (c_mid > CODE_MAX) begin
         code = SAMPLE_BITS'(CODE_MAX);
      end else begin
         code = SAMPLE_BITS'(c_mid);
      end
   end

endmodule

FILE: hw/rtl/biquad_df1_sample_filter.sv
// Top level of the Direct Form I biquad filter for unsigned converter samples.
//
// Input channel req_valid/req_ready/req_adc_sample carries one raw sample per
// transaction; result channel rsp_valid/rsp_ready/rsp_dac_code returns one
// filtered code per sample, in order.
// A sample is captured in the input register, evaluated combinationally by the
// biquad datapath and lands in the result register, which drives rsp_valid.
// One sample per cycle is sustained while rsp_ready stays high; the feedback
// path (five parallel multipliers, the 64-bit sum and saturation) between the
// input register and the history registers sets the clock limit.
// The csr_ port writes the five Q3.28 coefficients by index; any write to a
// valid index also clears the x and y history. Write only while idle.
// Reset clears coefficients, history and both valid flags.
// When rsp_ready is low the result holds, the input register still takes one
// more sample, and req_ready then drops until the result is taken.
module biquad_df1_sample_filter
   import bdf_pkg::*;
#(
   parameter int SAMPLE_BITS    = 12,
   parameter int COEF_FRAC_BITS = 28,
   parameter int OUT_FRAC_BITS  = 12,
   parameter int MID_SCALE      = 2048
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_adc_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]    rsp_dac_code,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int MID_BITS = $clog2(MID_SCALE + 1);
   localparam int X_BITS   = ((SAMPLE_BITS > MID_BITS) ? SAMPLE_BITS : MID_BITS) + 1;

   coef_set_type coef;
   logic         hist_clear;

   logic                        in_valid_ff, in_valid_in;
   logic signed [X_BITS-1:0]    x_ff, x_in;
   logic                        out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]      code_ff, code_in;
   logic signed [X_BITS-1:0]    x1_ff, x1_in, x2_ff, x2_in;
   logic signed [HIST_BITS-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic signed [HIST_BITS-1:0] y_next;
   logic [SAMPLE_BITS-1:0]      code;
   logic                        advance, take;

   bdf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coef         (coef),
      .hist_clear   (hist_clear)
   );

   bdf_math #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .X_BITS         (X_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .OUT_FRAC_BITS  (OUT_FRAC_BITS),
      .MID_SCALE      (MID_SCALE)
   ) u_math (
      .coef   (coef),
      .x0     (x_ff),
      .x1     (x1_ff),
      .x2     (x2_ff),
      .y1     (y1_ff),
      .y2     (y2_ff),
      .y_next (y_next),
      .code   (code)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      x_in         = x_ff;
      out_valid_in = out_valid_ff;
      code_in      = code_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (take) begin
         in_valid_in = 1'b1;
         x_in        = X_BITS'(req_adc_sample) - X_BITS'(MID_SCALE);
      end

      if (advance) begin
         out_valid_in = 1'b1;
         code_in      = code;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (hist_clear) begin
         x1_in = '0;
         x2_in = '0;
         y1_in = '0;
         y2_in = '0;
      end else if (advance) begin
         x1_in = x_ff;
         x2_in = x1_ff;
         y1_in = y_next;
         y2_in = y1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      code_ff <= code_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_dac_code = code_ff;

endmodule

FILE: test/biquad_df1_sample_filter_tb.sv
// Self-checking testbench for the biquad sample filter: directed table, then random phases.
module biquad_df1_sample_filter_tb
   import bdf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS     = 12;
   localparam int COEF_FRAC_BITS  = 28;
   localparam int OUT_FRAC_BITS   = 12;
   localparam int MID_SCALE       = 2048;
   localparam int CODE_MAX        = (1 << SAMPLE_BITS) - 1;
   localparam int IDLE_MAX        = 18;
   localparam int SETTLE_CYCLES   = 4;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int NUM_DIRECTED    = 34;

   localparam logic [CSR_DATA_BITS-1:0] ONE_Q28  = 32'h1000_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_MAX = 32'h7FFF_FFFF;
   localparam logic [CSR_DATA_BITS-1:0] COEF_MIN = 32'h8000_0000;
   localparam int HALF_Q28        = 1 << 27;
   localparam int A1_SPAN         = 3 * HALF_Q28;
   localparam int A2_TOP          = 214748364;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_SPARE_HI = 3'd7;

   localparam longint HIST_MAX = (longint'(1) <<< (HIST_BITS - 1)) - 1;
   localparam longint HIST_MIN = -(longint'(1) <<< (HIST_BITS - 1));

   typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_type;
   typedef enum {COEF_MILD, COEF_RAW, COEF_EXTREME} coef_style_type;

   typedef struct {
      row_kind_type                kind;
      logic [CSR_INDEX_BITS-1:0]   index;
      logic [CSR_DATA_BITS-1:0]    data;
      logic [SAMPLE_BITS-1:0]      adc;
      logic                        pinned;
      logic [SAMPLE_BITS-1:0]      code;
   } row_type;

   typedef struct packed {
      logic                   pinned;
      logic [SAMPLE_BITS-1:0] code;
   } pinned_code_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_adc_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_dac_code;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   coef_set_type                 coefs;
   logic signed [12:0]           x_hist1, x_hist2;
   logic signed [HIST_BITS-1:0]  y_hist1, y_hist2;

   logic [SAMPLE_BITS-1:0] dac_expect_q [$];
   pinned_code_type        typed_code_q [$];

   bit  calm = 1'b0;
   int  mismatches = 0;
   int  samples_sent = 0;
   int  codes_checked = 0;
   int  csr_writes = 0;
   int  cycle_count = 0;

   row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd0,    1'b1, 12'd2048},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b1, 12'd2048},
      '{ROW_WRITE,  REG_COEF_B0, ONE_Q28,  12'd0,    1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd0,    1'b1, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b1, 12'd4095},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd2048, 1'b1, 12'd2048},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'hA5A,  1'b1, 12'hA5A},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'h5A5,  1'b1, 12'h5A5},
      '{ROW_WRITE,  REG_COEF_B0, COEF_MAX, 12'd0,    1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b1, 12'd4095},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd0,    1'b1, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd2049, 1'b1, 12'd2056},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd2047, 1'b1, 12'd2040},
      '{ROW_WRITE,  REG_COEF_B0, COEF_MIN, 12'd0,    1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b1, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd0,    1'b1, 12'd4095},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd2049, 1'b1, 12'd2040},
      // drive the y history into saturation and the sum past 64 bits
      '{ROW_WRITE,  REG_COEF_B0, COEF_MAX, 12'd0,    1'b0, 12'd0},
      '{ROW_WRITE,  REG_COEF_B1, COEF_MAX, 12'd0,    1'b0, 12'd0},
      '{ROW_WRITE,  REG_COEF_B2, COEF_MAX, 12'd0,    1'b0, 12'd0},
      '{ROW_WRITE,  REG_COEF_A1, COEF_MIN, 12'd0,    1'b0, 12'd0},
      '{ROW_WRITE,  REG_COEF_A2, COEF_MIN, 12'd0,    1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd4095, 1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd0,    1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0, 32'h0,    12'd0,    1'b0, 12'd0},
      // unused index: history must survive
      '{ROW_WRITE,  CSR_INDEX_SPARE_LO, 32'h0,        12'd0,    1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0,        32'h0,        12'd0,    1'b0, 12'd0},
      '{ROW_WRITE,  CSR_INDEX_SPARE_HI, 32'hFFFF_FFFF, 12'd0,   1'b0, 12'd0},
      '{ROW_SAMPLE, REG_COEF_B0,        32'h0,        12'd4095, 1'b0, 12'd0}
   };

   biquad_df1_sample_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_sample (req_adc_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dac_code   (rsp_dac_code),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void clear_history();
      x_hist1 = '0;
      x_hist2 = '0;
      y_hist1 = '0;
      y_hist2 = '0;
   endfunction

   function automatic void apply_coef_write(input logic [CSR_INDEX_BITS-1:0] index,
                                            input logic [CSR_DATA_BITS-1:0] data);
      bit known;
      known = 1'b1;
      case (index)
         REG_COEF_B0: coefs.b0 = data;
         REG_COEF_B1: coefs.b1 = data;
         REG_COEF_B2: coefs.b2 = data;
         REG_COEF_A1: coefs.a1 = data;
         REG_COEF_A2: coefs.a2 = data;
         default: known = 1'b0;
      endcase
      if (known) clear_history();
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] filter_sample(input logic [SAMPLE_BITS-1:0] adc);
      longint x, acc, y, code;
      x = longint'(adc) - MID_SCALE;
      acc = ((longint'($signed(coefs.b0)) * x) <<< OUT_FRAC_BITS)
          + ((longint'($signed(coefs.b1)) * longint'(x_hist1)) <<< OUT_FRAC_BITS)
          + ((longint'($signed(coefs.b2)) * longint'(x_hist2)) <<< OUT_FRAC_BITS)
          - longint'($signed(coefs.a1)) * longint'(y_hist1)
          - longint'($signed(coefs.a2)) * longint'(y_hist2);
      y = ((acc >>> (COEF_FRAC_BITS - 1)) + 1) >>> 1;
      if (y > HIST_MAX) y = HIST_MAX;
      if (y < HIST_MIN) y = HIST_MIN;
      code = (((acc >>> (COEF_FRAC_BITS + OUT_FRAC_BITS - 1)) + 1) >>> 1) + MID_SCALE;
      if (code < 0) code = 0;
      if (code > CODE_MAX) code = CODE_MAX;
      x_hist2 = x_hist1;
      x_hist1 = x[12:0];
      y_hist2 = y_hist1;
      y_hist1 = y[HIST_BITS-1:0];
      return code[SAMPLE_BITS-1:0];
   endfunction

   function automatic int idle_draw();
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, IDLE_MAX);
   endfunction

   // track configuration, accepted samples and returned codes
   always @(posedge clock) begin : track
      pinned_code_type        tag;
      logic [SAMPLE_BITS-1:0] code;
      logic [SAMPLE_BITS-1:0] want;
      if (reset) begin
         coefs = '0;
         clear_history();
      end else begin
         if (csr_write_en) apply_coef_write(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            code = filter_sample(req_adc_sample);
            tag = typed_code_q.pop_front();
            if (tag.pinned) code = tag.code;
            dac_expect_q.push_back(code);
         end
         if (rsp_valid && rsp_ready) begin
            codes_checked++;
            if (dac_expect_q.size() == 0) begin
               $error("dac_code: expected none, actual %0d", rsp_dac_code);
               mismatches++;
            end else begin
               want = dac_expect_q.pop_front();
               if (rsp_dac_code !== want) begin
                  $error("dac_code: expected %0d, actual %0d", want, rsp_dac_code);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stalls on rsp_ready
   initial begin : result_sink
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] adc, input logic pinned,
                              input logic [SAMPLE_BITS-1:0] code);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_code_q.push_back('{pinned, code});
      req_valid <= 1'b1;
      req_adc_sample <= adc;
      do @(posedge clock); while (!(req_valid && req_ready));
      samples_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (dac_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      drain_results();
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_writes++;
   endtask

   initial begin : stimulus
      coef_style_type            style;
      logic [SAMPLE_BITS-1:0]    adc;
      logic [CSR_DATA_BITS-1:0]  coef;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE)
            write_csr(directed_rows[r].index, directed_rows[r].data);
         else
            send_sample(directed_rows[r].adc, directed_rows[r].pinned, directed_rows[r].code);
      end

      adc = SAMPLE_BITS'(MID_SCALE);
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         calm = (phase % 3 == 2);
         style = (phase % 4 == 1) ? COEF_RAW : (phase % 4 == 3) ? COEF_EXTREME : COEF_MILD;
         for (int i = REG_COEF_B0; i <= REG_COEF_A2; i++) begin
            case (style)
               COEF_MILD: begin
                  if (i == REG_COEF_A1)
                     coef = int'($urandom_range(0, 2 * A1_SPAN)) - A1_SPAN;
                  else if (i == REG_COEF_A2)
                     coef = $urandom_range(0, A2_TOP);
                  else
                     coef = int'($urandom_range(0, 2 * HALF_Q28)) - HALF_Q28;
               end
               COEF_RAW: coef = $urandom();
               default: begin
                  case ($urandom_range(0, 3))
                     0: coef = COEF_MAX;
                     1: coef = COEF_MIN;
                     2: coef = '0;
                     default: coef = ONE_Q28;
                  endcase
               end
            endcase
            write_csr(CSR_INDEX_BITS'(i), coef);
         end
         if ($urandom_range(0, 2) == 0)
            write_csr(CSR_INDEX_BITS'($urandom_range(CSR_INDEX_SPARE_LO, CSR_INDEX_SPARE_HI)),
                      $urandom());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // hold off until every code is back
            if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 0) drain_results();
            case ($urandom_range(0, 4))
               0, 1, 2: adc = SAMPLE_BITS'($urandom_range(0, CODE_MAX));
               3: ;
               default: adc = SAMPLE_BITS'(MID_SCALE + $urandom_range(0, 128) - 64);
            endcase
            send_sample(adc, 1'b0, '0);
         end
      end
      calm = 1'b0;
      drain_results();

      $display("Filtered %0d samples, checked %0d codes, %0d coefficient writes",
               samples_sent, codes_checked, csr_writes);
      $display("Covered clamping, y saturation, sum wrap, spare indexes and %0d random phases",
               NUM_PHASES);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: biquad_df1_sample_filter.f
hw/rtl/bdf_pkg.sv
hw/rtl/bdf_csr.sv
hw/rtl/bdf_math.sv
hw/rtl/biquad_df1_sample_filter.sv
test/biquad_df1_sample_filter_tb.sv
